/* sv/gcs_pkg.sv */
// ----------------------------------------------------------------------------
// Gray contrast stretch package
// Shared sizes, constants and the controller state type.
// ----------------------------------------------------------------------------
package gcs_pkg;

    // Frame store geometry.
    localparam int FRAME_DEPTH = 262144;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int CNT_W       = 19;
    localparam int PIX_W       = 8;
    localparam int NUM_W       = 2 * PIX_W;
    localparam int STEP_W      = $clog2(PIX_W);

    // Reset values of the frame levels and the frame size register, and the full output level.
    localparam logic [PIX_W-1:0] LEVEL_LOW_RST  = '1;
    localparam logic [PIX_W-1:0] LEVEL_HIGH_RST = '0;
    localparam logic [PIX_W-1:0] LEVEL_FULL     = '1;
    localparam logic [CNT_W-1:0] FRAME_MAX      = CNT_W'(FRAME_DEPTH);

    // Item kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV
    } t_state;

endpackage

/* sv/gcs_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle; read data is registered.
// ----------------------------------------------------------------------------
module gcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port share the address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/gray_contrast_stretch_unit.sv */
// ----------------------------------------------------------------------------
// Gray contrast stretch unit
// Loads one 8-bit gray frame into a frame store and drains it stretched to
// the full 0..255 range.
// ----------------------------------------------------------------------------
// A load item (kind 0) leaves busy low, so loads may be issued on every
// cycle while no drain is in progress. A drain item (kind 1) that yields a
// result keeps busy high through one frame store read, then an 8-step
// restoring divider, one quotient bit per cycle, or through the read alone
// when the level saturates or the frame is flat; the result strobe comes in
// the first cycle with busy low again, as a single-cycle strobe that the
// receiver must take. Ignored items (extra loads, early drains) leave busy
// low. The frame store is one single-port RAM of 262144 bytes with no
// clearing pass after reset. The frame size may be written only while busy
// is low and no strobe is due.
// ----------------------------------------------------------------------------
module gray_contrast_stretch_unit
    import gcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_kind,
    input  logic [PIX_W-1:0]  i_pixel,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    output logic              o_strobe,
    output logic [PIX_W-1:0]  o_out_pixel,
    output logic              o_last
);

    // Control registers.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_frame_pixels;
    logic [PIX_W-1:0]   r_low, n_low;
    logic [PIX_W-1:0]   r_high, n_high;
    logic [CNT_W-1:0]   r_load_count, n_load_count;
    logic [ADDR_W-1:0]  r_drain_count, n_drain_count;
    logic               r_is_last, n_is_last;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_strobe, n_strobe;

    // Payload registers.
    logic [PIX_W-1:0]   r_span, n_span;
    logic [PIX_W-1:0]   r_rem, n_rem;
    logic [PIX_W-1:0]   r_num_lo, n_num_lo;
    logic [PIX_W-1:0]   r_quot, n_quot;
    logic [PIX_W-1:0]   r_out_pixel, n_out_pixel;
    logic               r_last, n_last;

    // RAM port.
    logic               ram_we;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_addr;
    logic [PIX_W-1:0]   ram_rdata;

    // Decoded item.
    logic               accept;
    logic [CNT_W-1:0]   active_n;
    logic               frame_full;
    logic               do_load;
    logic               do_drain;

    // Datapath helpers.
    logic [PIX_W-1:0]   diff;
    logic [NUM_W-1:0]   numer;
    logic [PIX_W:0]     rem_shift;
    logic               rem_ge;
    logic [PIX_W:0]     rem_sub;
    logic               quot_bit;

    gcs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (FRAME_DEPTH)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (i_pixel),
        .o_rdata (ram_rdata)
    );

    // Effective frame size: zero acts as one, oversize clamps to the store.
    always_comb begin
        if (r_frame_pixels == '0) begin
            active_n = CNT_W'(1);
        end else if (r_frame_pixels > FRAME_MAX) begin
            active_n = FRAME_MAX;
        end else begin
            active_n = r_frame_pixels;
        end
    end

    assign accept     = start && !busy;
    assign frame_full = (r_load_count >= active_n);
    assign do_load    = accept && (i_kind == KIND_LOAD) && !frame_full;
    assign do_drain   = accept && (i_kind == KIND_DRAIN) && frame_full;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (do_drain) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if ((r_high > r_low) && (ram_rdata > r_low) && (ram_rdata < r_high)) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (r_step == STEP_W'(PIX_W - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Handshake and frame store control.
    always_comb begin
        busy     = 1'b1;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        ram_addr = r_drain_count;
        case (r_state)
            S_IDLE: begin
                busy   = 1'b0;
                ram_we = do_load;
                ram_re = do_drain;
                if (i_kind == KIND_LOAD) begin
                    ram_addr = r_load_count[ADDR_W-1:0];
                end
            end
            S_READ: begin
                busy = 1'b1;
            end
            S_DIV: begin
                busy = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // Numerator (p - low) * 255 and one restoring division step.
    assign diff      = ram_rdata - r_low;
    assign numer     = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};
    assign rem_shift = {r_rem, r_num_lo[PIX_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, r_span});
    assign rem_sub   = rem_shift - {1'b0, r_span};
    assign quot_bit  = rem_ge;

    // Datapath next values.
    always_comb begin
        n_low         = r_low;
        n_high        = r_high;
        n_load_count  = r_load_count;
        n_drain_count = r_drain_count;
        n_is_last     = r_is_last;
        n_step        = r_step;
        n_strobe      = 1'b0;
        n_span        = r_span;
        n_rem         = r_rem;
        n_num_lo      = r_num_lo;
        n_quot        = r_quot;
        n_out_pixel   = r_out_pixel;
        n_last        = r_last;

        case (r_state)
            S_IDLE: begin
                // A load writes the store and tracks the level range.
                if (do_load) begin
                    if (i_pixel < r_low) begin
                        n_low = i_pixel;
                    end
                    if (i_pixel > r_high) begin
                        n_high = i_pixel;
                    end
                    n_load_count = r_load_count + CNT_W'(1);
                end
                // A drain decides now whether it closes the frame.
                if (do_drain) begin
                    n_is_last = ({1'b0, r_drain_count} + CNT_W'(1)) >= active_n;
                end
            end
            S_READ: begin
                n_span   = r_high - r_low;
                n_rem    = numer[NUM_W-1:PIX_W];
                n_num_lo = numer[PIX_W-1:0];
                n_quot   = '0;
                n_step   = '0;
                n_last   = r_is_last;
                // Saturated or flat cases finish without dividing.
                if (r_high <= r_low || ram_rdata <= r_low) begin
                    n_out_pixel = '0;
                    n_strobe    = 1'b1;
                end else if (ram_rdata >= r_high) begin
                    n_out_pixel = LEVEL_FULL;
                    n_strobe    = 1'b1;
                end
                // Levels are captured, so the frame can be closed here.
                if (r_is_last) begin
                    n_low         = LEVEL_LOW_RST;
                    n_high        = LEVEL_HIGH_RST;
                    n_load_count  = '0;
                    n_drain_count = '0;
                end else begin
                    n_drain_count = r_drain_count + ADDR_W'(1);
                end
            end
            S_DIV: begin
                n_rem    = rem_ge ? rem_sub[PIX_W-1:0] : rem_shift[PIX_W-1:0];
                n_num_lo = {r_num_lo[PIX_W-2:0], 1'b0};
                n_quot   = {r_quot[PIX_W-2:0], quot_bit};
                n_step   = r_step + STEP_W'(1);
                if (r_step == STEP_W'(PIX_W - 1)) begin
                    n_out_pixel = {r_quot[PIX_W-2:0], quot_bit};
                    n_strobe    = 1'b1;
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_frame_pixels <= FRAME_MAX;
            r_low          <= LEVEL_LOW_RST;
            r_high         <= LEVEL_HIGH_RST;
            r_load_count   <= '0;
            r_drain_count  <= '0;
            r_is_last      <= 1'b0;
            r_step         <= '0;
            r_strobe       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_low         <= n_low;
            r_high        <= n_high;
            r_load_count  <= n_load_count;
            r_drain_count <= n_drain_count;
            r_is_last     <= n_is_last;
            r_step        <= n_step;
            r_strobe      <= n_strobe;
            if (i_cfg_we) begin
                r_frame_pixels <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_span      <= n_span;
        r_rem       <= n_rem;
        r_num_lo    <= n_num_lo;
        r_quot      <= n_quot;
        r_out_pixel <= n_out_pixel;
        r_last      <= n_last;
    end

    assign o_strobe    = r_strobe;
    assign o_out_pixel = r_out_pixel;
    assign o_last      = r_last;

    // Checks.
    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == S_READ || $past(r_state) == S_DIV))
        else $error("result strobe without a drain in progress");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_count <= FRAME_MAX)
        else $error("load count ran past the frame store");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_span))
        else $error("divider remainder not below the span");

    a_busy_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_drain |=> (busy && r_state == S_READ))
        else $error("drain item did not start a frame store read");

endmodule

/* verif/gcs_stretch_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gray contrast stretch result checker
// Watches the item, frame size and result channels of the stretch unit,
// keeps its own copy of the frame and the levels, works out each stretched
// pixel and compares it with what the unit returns.
// ----------------------------------------------------------------------------
module gcs_stretch_check
    import gcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             i_kind,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    input  logic             o_strobe,
    input  logic [PIX_W-1:0] o_out_pixel,
    input  logic             o_last,
    output int               o_mismatches,
    output int               o_pending,
    output int               o_checked
);

    // One stretched pixel as the unit should return it.
    typedef struct packed {
        logic [PIX_W-1:0] level;
        logic             last;
    } t_stretched;

    logic [PIX_W-1:0] frame_copy [FRAME_DEPTH];
    logic [CNT_W-1:0] size_reg    = FRAME_MAX;
    logic [CNT_W-1:0] loaded      = '0;
    logic [CNT_W-1:0] drained     = '0;
    logic [PIX_W-1:0] low_seen    = LEVEL_LOW_RST;
    logic [PIX_W-1:0] high_seen   = LEVEL_HIGH_RST;
    t_stretched       stretched_q [$];
    int               mismatch_count = 0;
    int               checked_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = stretched_q.size();
    assign o_checked    = checked_count;

    // A size of zero behaves as one pixel, anything past the store as a full store.
    function automatic logic [CNT_W-1:0] frame_len(input logic [CNT_W-1:0] sz);
        if (sz == '0) begin
            return CNT_W'(1);
        end
        if (sz > FRAME_MAX) begin
            return FRAME_MAX;
        end
        return sz;
    endfunction

    // Maps a stored level onto the full range; a flat frame gives zero.
    function automatic logic [PIX_W-1:0] stretch_level(input logic [PIX_W-1:0] p,
                                                       input logic [PIX_W-1:0] lo,
                                                       input logic [PIX_W-1:0] hi);
        int unsigned scaled;
        if (hi <= lo || p <= lo) begin
            return '0;
        end
        if (p >= hi) begin
            return LEVEL_FULL;
        end
        scaled = (32'(p - lo) * 32'(LEVEL_FULL)) / 32'(hi - lo);
        return scaled[PIX_W-1:0];
    endfunction

    // Results are taken first, then a size write, then the item of this edge.
    always @(posedge i_clk) begin
        t_stretched       want;
        logic [CNT_W-1:0] n;
        if (!i_rst_n) begin
            size_reg  = FRAME_MAX;
            loaded    = '0;
            drained   = '0;
            low_seen  = LEVEL_LOW_RST;
            high_seen = LEVEL_HIGH_RST;
            stretched_q.delete();
        end else begin
            if (o_strobe === 1'b1) begin
                if (stretched_q.size() == 0) begin
                    $error("Stretched pixel %0d arrived with nothing outstanding.",
                           o_out_pixel);
                    mismatch_count++;
                end else begin
                    want = stretched_q.pop_front();
                    checked_count++;
                    if (o_out_pixel !== want.level) begin
                        $error("out_pixel: expected %0d, actual %0d", want.level,
                               o_out_pixel);
                        mismatch_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, o_last);
                        mismatch_count++;
                    end
                end
            end

            if (i_cfg_we === 1'b1) begin
                size_reg = i_cfg_wdata;
            end

            if (start === 1'b1 && busy === 1'b0) begin
                n = frame_len(size_reg);
                if (i_kind == KIND_LOAD) begin
                    // Loads past the end of the frame are dropped.
                    if (loaded < n) begin
                        frame_copy[loaded] = i_pixel;
                        if (i_pixel < low_seen) begin
                            low_seen = i_pixel;
                        end
                        if (i_pixel > high_seen) begin
                            high_seen = i_pixel;
                        end
                        loaded = loaded + 1'b1;
                    end
                end else if (loaded >= n) begin
                    // Drains only count once the whole frame is in.
                    want.level = stretch_level(frame_copy[drained], low_seen, high_seen);
                    want.last  = ({1'b0, drained} + 1'b1 >= {1'b0, n});
                    stretched_q.push_back(want);
                    if (want.last) begin
                        loaded    = '0;
                        drained   = '0;
                        low_seen  = LEVEL_LOW_RST;
                        high_seen = LEVEL_HIGH_RST;
                    end else begin
                        drained = drained + 1'b1;
                    end
                end
            end
        end
    end

endmodule

/* verif/gray_contrast_stretch_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gray contrast stretch unit testbench
// Loads and drains frames of many sizes, with directed edge cases first and
// then random frames with stray items, bursty issue and mid-frame size
// changes; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module gray_contrast_stretch_unit_tb
    import gcs_pkg::*;
();

    localparam int RANDOM_ITEMS  = 650;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 300000;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    logic             i_kind      = KIND_LOAD;
    logic [PIX_W-1:0] i_pixel     = '0;
    logic             i_cfg_we    = 1'b0;
    logic [CNT_W-1:0] i_cfg_wdata = '0;
    logic             o_strobe;
    logic [PIX_W-1:0] o_out_pixel;
    logic             o_last;

    int mismatches;
    int pending;
    int checked;
    int cycle_count  = 0;
    int burst_left   = 0;
    int load_items   = 0;
    int drain_items  = 0;
    int size_writes  = 0;
    int random_items = 0;

    gray_contrast_stretch_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_pixel     (i_pixel),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_strobe    (o_strobe),
        .o_out_pixel (o_out_pixel),
        .o_last      (o_last)
    );

    gcs_stretch_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_kind       (i_kind),
        .i_pixel      (i_pixel),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_strobe     (o_strobe),
        .o_out_pixel  (o_out_pixel),
        .o_last       (o_last),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Issues one item; the sender idles between bursts of random length.
    task automatic send_item(input logic kind, input logic [PIX_W-1:0] level);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
        end
        i_kind  <= kind;
        i_pixel <= level;
        start   <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        burst_left--;
        if (kind == KIND_LOAD) begin
            load_items++;
        end else begin
            drain_items++;
        end
    endtask

    // Holds off until every result is in and the unit has settled.
    task automatic wait_quiet();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || busy !== 1'b0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frame_size(input logic [CNT_W-1:0] value);
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        size_writes++;
    endtask

    // Loads n pixels in lo..hi, optionally with early drains mixed in.
    task automatic load_pixels(input int n, input int lo, input int hi, input bit noisy);
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 11) == 0) begin
                send_item(KIND_DRAIN, PIX_W'($urandom_range(0, 255)));
            end
            send_item(KIND_LOAD, PIX_W'($urandom_range(lo, hi)));
        end
    endtask

    // Drains n pixels, optionally with surplus loads mixed in.
    task automatic drain_pixels(input int n, input bit noisy);
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 11) == 0) begin
                send_item(KIND_LOAD, PIX_W'($urandom_range(0, 255)));
            end
            send_item(KIND_DRAIN, PIX_W'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int n;
        int k;
        int lo;
        int hi;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Four-pixel frame with both level extremes, an early drain, a surplus
        // load and a drain after the frame has ended.
        write_frame_size(CNT_W'(4));
        send_item(KIND_LOAD, 8'd0);
        send_item(KIND_DRAIN, 8'hA5);
        send_item(KIND_LOAD, 8'd255);
        send_item(KIND_LOAD, 8'd128);
        send_item(KIND_LOAD, 8'd1);
        send_item(KIND_LOAD, 8'd77);
        drain_pixels(4, 1'b0);
        send_item(KIND_DRAIN, 8'h5A);

        // A size of zero acts as a single pixel, which is a flat frame.
        write_frame_size('0);
        send_item(KIND_LOAD, 8'd200);
        send_item(KIND_DRAIN, 8'd0);

        // Oversized setting, then the frame is cut short under partial load.
        write_frame_size('1);
        send_item(KIND_LOAD, 8'd10);
        send_item(KIND_LOAD, 8'd20);
        send_item(KIND_LOAD, 8'd30);
        send_item(KIND_DRAIN, 8'hFF);
        write_frame_size(CNT_W'(2));
        drain_pixels(2, 1'b0);

        // Flat three-pixel frame.
        write_frame_size(CNT_W'(3));
        load_pixels(3, 7, 7, 1'b0);
        drain_pixels(3, 1'b0);

        // Random frames: mostly clean load-then-drain, with stray items.
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                // Start with a large frame, then shrink it to at most the loaded count.
                case ($urandom_range(0, 2))
                    0: write_frame_size(FRAME_MAX);
                    1: write_frame_size('1);
                    default: write_frame_size(CNT_W'($urandom_range(20, 1000)));
                endcase
                k = $urandom_range(1, 12);
                load_pixels(k, 0, 255, 1'b1);
                n = $urandom_range(0, k);
                write_frame_size(CNT_W'(n));
                if (n == 0) begin
                    n = 1;
                end
                drain_pixels(n, 1'b1);
                random_items += k + n;
            end else begin
                case ($urandom_range(0, 19))
                    0: n = 0;
                    1: n = 1;
                    2, 3: n = $urandom_range(33, 96);
                    default: n = $urandom_range(2, 16);
                endcase
                write_frame_size(CNT_W'(n));
                if (n == 0) begin
                    n = 1;
                end
                case ($urandom_range(0, 3))
                    0: begin
                        lo = 0;
                        hi = 255;
                    end
                    1: begin
                        lo = $urandom_range(0, 247);
                        hi = lo + $urandom_range(1, 8);
                    end
                    2: begin
                        lo = $urandom_range(0, 255);
                        hi = lo;
                    end
                    default: begin
                        lo = $urandom_range(0, 255);
                        hi = $urandom_range(lo, 255);
                    end
                endcase
                load_pixels(n, lo, hi, 1'b1);
                drain_pixels(n, 1'b1);
                random_items += 2 * n;
            end
        end

        wait_quiet();
        $display("Issued %0d loads and %0d drains over %0d frame size settings.",
                 load_items, drain_items, size_writes);
        $display("Compared %0d stretched pixels with their frame-end marks.", checked);
        if (pending != 0) begin
            $error("%0d stretched pixels never arrived.", pending);
        end
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/gcs_pkg.sv
sv/gcs_ram.sv
sv/gray_contrast_stretch_unit.sv
verif/gcs_stretch_check.sv
verif/gray_contrast_stretch_unit_tb.sv
